// File: rtl/frse_pkg.sv
package frse_pkg;

  // Internal width of the running totals; result fields are fixed at 48 bits.
  localparam int TOTAL_WIDTH = 48;
  localparam int FIELD_W     = 48;

  localparam logic [7:0] CAP_RESET  = 8'd5;
  localparam logic [7:0] RUN_LEN_MAX = 8'hFF;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_A  = 8'h41;
  localparam logic [7:0] CHAR_C  = 8'h43;
  localparam logic [7:0] CHAR_G  = 8'h47;
  localparam logic [7:0] CHAR_T  = 8'h54;
  localparam logic [7:0] CHAR_N  = 8'h4E;
  localparam logic [7:0] CHAR_LO_A = 8'h61;
  localparam logic [7:0] CHAR_LO_Z = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef enum logic [1:0] {
    LINE_HEADER = 2'd0,
    LINE_SEQ    = 2'd1,
    LINE_PLUS   = 2'd2,
    LINE_QUAL   = 2'd3
  } line_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] len;
    logic       open;
  } run_trk_t;

  localparam run_trk_t RUN_CLEAR = '{ch: 8'd0, len: 8'd0, open: 1'b0};

  function automatic logic [TOTAL_WIDTH-1:0] sat_add(
    input logic [TOTAL_WIDTH-1:0] a,
    input logic [TOTAL_WIDTH-1:0] b
  );
    logic [TOTAL_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : s[TOTAL_WIDTH-1:0];
  endfunction

endpackage

// File: rtl/fastq_rle_size_estimator.sv
// FASTQ run-length size estimator.
//
// Input channel (in_valid/in_ready): one byte of FASTQ text per request, with
// in_chunk_end marking the last byte of a chunk. Result channel
// (out_valid/out_ready): one result per input request carrying the running
// kept, compressed and run totals and the record line the next byte falls in.
// cfg_we/cfg_wdata write run_cost_cap; write it only while the block is idle.
//
// A request's result shows right after the edge that accepts it. Throughput
// is one byte per cycle while out_ready keeps the result draining; the totals
// and run trackers update in a single register stage, and the result is read
// straight from that state. in_ready stays high while the result register is
// empty or being drained, so a stalled receiver holds the current result and
// blocks further input without losing anything.
//
// Reset (rst_n low, synchronous): totals, line counter and run trackers clear,
// run_cost_cap returns to 5, and no result is pending.
module fastq_rle_size_estimator
  import frse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_text_byte,
  input  logic               in_chunk_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_kept_total,
  output logic [FIELD_W-1:0] out_compressed_total,
  output logic [FIELD_W-1:0] out_run_total,
  output logic [1:0]         out_line_kind
);

  logic [7:0]             cap_r;
  line_kind_t             line_r, line_nxt;
  run_trk_t               seq_r, seq_nxt, qual_r, qual_nxt;
  logic [TOTAL_WIDTH-1:0] kept_cnt_r, kept_cnt_nxt;
  logic [TOTAL_WIDTH-1:0] comp_cnt_r, comp_cnt_nxt;
  logic [TOTAL_WIDTH-1:0] run_cnt_r, run_cnt_nxt;
  logic                   out_valid_r;

  logic       in_acc;
  logic       is_cr, is_lf, on_seq, on_qual;
  logic [7:0] upper;
  logic       base_ok, keep, match, close_run;
  logic [7:0] feed_ch, cost;
  run_trk_t   sel_trk, sel_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    is_cr   = (in_text_byte == CHAR_CR);
    is_lf   = (in_text_byte == CHAR_LF);
    on_seq  = (line_r == LINE_SEQ);
    on_qual = (line_r == LINE_QUAL);

    upper = in_text_byte;
    if (in_text_byte >= CHAR_LO_A && in_text_byte <= CHAR_LO_Z) begin
      upper = in_text_byte - CASE_DELTA;
    end
    base_ok = (upper == CHAR_A) || (upper == CHAR_C) || (upper == CHAR_G) ||
              (upper == CHAR_T) || (upper == CHAR_N);

    // Only the tracker of the current line is touched by a byte; a chunk end clears both.
    sel_trk = on_qual ? qual_r : seq_r;
    feed_ch = on_qual ? in_text_byte : upper;
    keep    = !is_cr && !is_lf && ((on_seq && base_ok) || on_qual);
    match   = sel_trk.open && (sel_trk.ch == feed_ch);

    // A run closes on the newline ending its line or when a new char arrives.
    close_run = sel_trk.open && (on_seq || on_qual) &&
                ((is_lf) || (keep && !match));
    cost = (sel_trk.len > cap_r) ? cap_r : sel_trk.len;

    sel_nxt = sel_trk;
    if (is_lf) begin
      sel_nxt = RUN_CLEAR;
    end else if (keep) begin
      if (match) begin
        if (sel_trk.len != RUN_LEN_MAX) begin
          sel_nxt.len = sel_trk.len + 8'd1;
        end
      end else begin
        sel_nxt = '{ch: feed_ch, len: 8'd1, open: 1'b1};
      end
    end
  end

  always_comb begin
    seq_nxt  = seq_r;
    qual_nxt = qual_r;
    line_nxt = line_r;
    if (on_seq) begin
      seq_nxt = sel_nxt;
    end
    if (on_qual) begin
      qual_nxt = sel_nxt;
    end
    if (is_lf) begin
      line_nxt = line_kind_t'(line_r + 2'd1);
    end
    if (in_chunk_end) begin
      line_nxt = LINE_HEADER;
      seq_nxt  = RUN_CLEAR;
      qual_nxt = RUN_CLEAR;
    end

    kept_cnt_nxt = keep ? sat_add(kept_cnt_r, TOTAL_WIDTH'(1)) : kept_cnt_r;
    comp_cnt_nxt = close_run ? sat_add(comp_cnt_r, TOTAL_WIDTH'(cost)) : comp_cnt_r;
    run_cnt_nxt  = close_run ? sat_add(run_cnt_r, TOTAL_WIDTH'(1)) : run_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      line_r      <= LINE_HEADER;
      seq_r       <= RUN_CLEAR;
      qual_r      <= RUN_CLEAR;
      kept_cnt_r  <= '0;
      comp_cnt_r  <= '0;
      run_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (in_acc) begin
        line_r     <= line_nxt;
        seq_r      <= seq_nxt;
        qual_r     <= qual_nxt;
        kept_cnt_r <= kept_cnt_nxt;
        comp_cnt_r <= comp_cnt_nxt;
        run_cnt_r  <= run_cnt_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // State only moves on an accepted request, so it doubles as the result.
  assign out_valid            = out_valid_r;
  assign out_kept_total       = FIELD_W'(kept_cnt_r);
  assign out_compressed_total = FIELD_W'(comp_cnt_r);
  assign out_run_total        = FIELD_W'(run_cnt_r);
  assign out_line_kind        = line_r;

`ifndef SYNTHESIS
  a_line_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(line_r) && $stable(kept_cnt_r))
    else $error("state changed without an accepted request");

  a_run_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (run_cnt_r - $past(run_cnt_r)) <= TOTAL_WIDTH'(1))
    else $error("run total grew by more than one");

  a_cost_cap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (comp_cnt_r - $past(comp_cnt_r)) <= TOTAL_WIDTH'($past(cap_r)))
    else $error("run cost exceeded cap");

  a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r.open |-> seq_r.len != 8'd0)
    else $error("open sequence run has zero length");

  a_qual_len: assert property (@(posedge clk) disable iff (!rst_n)
    qual_r.open |-> qual_r.len != 8'd0)
    else $error("open quality run has zero length");
`endif

endmodule

// File: dv/tb_fastq_rle_size_estimator.sv
module tb_fastq_rle_size_estimator;
  timeunit 1ns;
  timeprecision 1ps;

  import frse_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam int SEG_ITEMS      = 220;

  localparam logic [7:0] CHAR_AT   = 8'h40;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [7:0] text;
    logic       chunk_end;
  } fastq_byte_t;

  typedef struct packed {
    logic [FIELD_W-1:0] kept;
    logic [FIELD_W-1:0] comp;
    logic [FIELD_W-1:0] runs;
    logic [1:0]         line;
  } size_totals_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] len;
    logic       open;
  } run_track_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [7:0]         cfg_wdata = 8'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_text_byte = 8'd0;
  logic               in_chunk_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FIELD_W-1:0] out_kept_total;
  logic [FIELD_W-1:0] out_compressed_total;
  logic [FIELD_W-1:0] out_run_total;
  logic [1:0]         out_line_kind;

  fastq_rle_size_estimator u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_text_byte         (in_text_byte),
    .in_chunk_end         (in_chunk_end),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kept_total       (out_kept_total),
    .out_compressed_total (out_compressed_total),
    .out_run_total        (out_run_total),
    .out_line_kind        (out_line_kind)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fastq_byte_t  text_backlog[$];
  size_totals_t expected_totals[$];
  int           send_idle_pct = 6;
  int           recv_idle_pct = 72;
  int           queued_count = 0;
  int           mismatches = 0;
  int           stall_cycles = 0;
  logic         req_accepted = 1'b0;

  // shadow of the estimator state
  logic [7:0]             cap_shadow;
  logic [1:0]             line_pos;
  run_track_t             seq_run;
  run_track_t             qual_run;
  logic [TOTAL_WIDTH-1:0] kept_sum;
  logic [TOTAL_WIDTH-1:0] comp_sum;
  logic [TOTAL_WIDTH-1:0] run_sum;

  function automatic logic [TOTAL_WIDTH-1:0] sat_sum(input logic [TOTAL_WIDTH-1:0] a,
                                                     input logic [TOTAL_WIDTH-1:0] b);
    if (b > TOTAL_MAX - a) return TOTAL_MAX;
    return a + b;
  endfunction

  task automatic charge_run(input run_track_t t);
    logic [7:0] cost;
    if (t.open) begin
      cost = (t.len > cap_shadow) ? cap_shadow : t.len;
      comp_sum = sat_sum(comp_sum, {{(TOTAL_WIDTH-8){1'b0}}, cost});
      run_sum  = sat_sum(run_sum, TOTAL_WIDTH'(1));
    end
  endtask

  task automatic extend_run(inout run_track_t t, input logic [7:0] c);
    if (t.open && t.ch == c) begin
      if (t.len != RUN_LEN_MAX) t.len = t.len + 8'd1;
    end else begin
      charge_run(t);
      t.ch   = c;
      t.len  = 8'd1;
      t.open = 1'b1;
    end
  endtask

  task automatic estimate_byte(input logic [7:0] c, input logic ce, output size_totals_t r);
    logic [7:0] up;
    up = c;
    if (c == CHAR_LF) begin
      if (line_pos == LINE_SEQ) begin
        charge_run(seq_run);
        seq_run = '0;
      end else if (line_pos == LINE_QUAL) begin
        charge_run(qual_run);
        qual_run = '0;
      end
      line_pos = line_pos + 2'd1;
    end else if (c != CHAR_CR) begin
      if (line_pos == LINE_SEQ) begin
        if (up >= CHAR_LO_A && up <= CHAR_LO_Z) up = up - CASE_DELTA;
        if (up == CHAR_A || up == CHAR_C || up == CHAR_G || up == CHAR_T || up == CHAR_N) begin
          kept_sum = sat_sum(kept_sum, TOTAL_WIDTH'(1));
          extend_run(seq_run, up);
        end
      end else if (line_pos == LINE_QUAL) begin
        kept_sum = sat_sum(kept_sum, TOTAL_WIDTH'(1));
        extend_run(qual_run, c);
      end
    end
    // chunk end drops open runs without charging them
    if (ce) begin
      line_pos = LINE_HEADER;
      seq_run  = '0;
      qual_run = '0;
    end
    r.kept = kept_sum;
    r.comp = comp_sum;
    r.runs = run_sum;
    r.line = line_pos;
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // monitor and predictor
  always @(posedge clk) begin : monitor
    size_totals_t observed;
    size_totals_t predicted;
    if (!rst_n) begin
      cap_shadow = CAP_RESET;
      line_pos   = LINE_HEADER;
      seq_run    = '0;
      qual_run   = '0;
      kept_sum   = '0;
      comp_sum   = '0;
      run_sum    = '0;
    end else begin
      if (cfg_we) cap_shadow = cfg_wdata;
      if (out_valid && out_ready) begin
        observed.kept = out_kept_total;
        observed.comp = out_compressed_total;
        observed.runs = out_run_total;
        observed.line = out_line_kind;
        if (expected_totals.size() == 0) begin
          mismatches++;
          $display({"%0t: unexpected result, expected none, ",
                    "actual kept %0d comp %0d runs %0d line %0d"},
                   $time, observed.kept, observed.comp, observed.runs, observed.line);
        end else begin
          predicted = expected_totals.pop_front();
          check_field("kept_total", predicted.kept, observed.kept);
          check_field("compressed_total", predicted.comp, observed.comp);
          check_field("run_total", predicted.runs, observed.runs);
          check_field("line_kind", {{(FIELD_W-2){1'b0}}, predicted.line},
                      {{(FIELD_W-2){1'b0}}, observed.line});
        end
      end
      if (in_valid && in_ready) begin
        estimate_byte(in_text_byte, in_chunk_end, predicted);
        expected_totals.push_back(predicted);
      end
    end
    req_accepted <= in_valid && in_ready;
  end

  // request driver
  always @(negedge clk) begin : driver
    fastq_byte_t nxt;
    if (!in_valid || req_accepted) begin
      if (rst_n && text_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = text_backlog.pop_front();
        in_valid     <= 1'b1;
        in_text_byte <= nxt.text;
        in_chunk_end <= nxt.chunk_end;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_req(input logic [7:0] c, input logic ce);
    fastq_byte_t b;
    b.text = c;
    b.chunk_end = ce;
    text_backlog.push_back(b);
    queued_count++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_req(s[i], 1'b0);
  endtask

  function automatic logic rand_ce();
    return $urandom_range(249) == 0;
  endfunction

  function automatic logic [7:0] any_but_lf();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CHAR_LF);
    return c;
  endfunction

  task automatic push_eol();
    if ($urandom_range(4) == 0) push_req(CHAR_CR, 1'b0);
    push_req(CHAR_LF, rand_ce());
  endtask

  task automatic fill_segment();
    logic [7:0] sym;
    logic       letter;
    int         run_len;
    queued_count = 0;
    while (queued_count < SEG_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        // noise: raw bytes, newlines included
        repeat ($urandom_range(12, 1)) push_req(8'($urandom_range(255)), rand_ce());
      end else begin
        push_req(CHAR_AT, 1'b0);
        repeat ($urandom_range(5)) push_req(any_but_lf(), rand_ce());
        push_eol();
        repeat ($urandom_range(6, 1)) begin
          letter = 1'b1;
          case ($urandom_range(5))
            0: sym = CHAR_A;
            1: sym = CHAR_C;
            2: sym = CHAR_G;
            3: sym = CHAR_T;
            4: sym = CHAR_N;
            default: begin
              sym = any_but_lf();
              letter = 1'b0;
            end
          endcase
          run_len = ($urandom_range(99) < 3) ? $urandom_range(300, 250) : $urandom_range(8, 1);
          repeat (run_len)
            push_req((letter && $urandom_range(2) == 0) ? (sym | CASE_DELTA) : sym, rand_ce());
        end
        push_eol();
        push_req(CHAR_PLUS, 1'b0);
        repeat ($urandom_range(2)) push_req(any_but_lf(), rand_ce());
        push_eol();
        repeat ($urandom_range(6, 1)) begin
          sym = ($urandom_range(9) == 0) ? any_but_lf() : 8'($urandom_range(73, 33));
          run_len = ($urandom_range(99) < 3) ? $urandom_range(300, 250) : $urandom_range(8, 1);
          repeat (run_len) push_req(sym, rand_ce());
        end
        push_eol();
      end
    end
  endtask

  task automatic drain_block();
    while (text_backlog.size() != 0 || in_valid || expected_totals.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cap(input logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: case folding, junk bases, CR, byte extremes, chunk end mid-run and on LF
    push_text("@\naAcxgGtnN\r\n+\n");
    push_req(8'h00, 1'b0);
    push_req(8'h00, 1'b0);
    push_req(8'hFF, 1'b0);
    push_text("!\r\n@\nT");
    push_req(CHAR_T, 1'b1);
    push_req(CHAR_LF, 1'b1);
    drain_block();

    write_cap(8'd1);
    fill_segment();
    drain_block();
    write_cap(8'd255);
    fill_segment();
    drain_block();

    send_idle_pct = 72;
    recv_idle_pct = 6;
    // zero cap: runs still counted, cost nothing
    write_cap(8'd0);
    fill_segment();
    drain_block();
    write_cap(8'($urandom_range(254, 2)));
    fill_segment();
    drain_block();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cap(8'($urandom_range(254, 2)));
    fill_segment();
    drain_block();
    write_cap(8'd255);
    fill_segment();
    drain_block();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
